/* rtl/scpq_pkg.sv */
// Shared types, codes, constants and the segment type classifier for the priority queue.
package scpq_pkg;

  localparam int DefQueueDepth = 16;
  localparam int DefHandleBits = 16;
  localparam int HandleWidth = 16;
  localparam int SegTypeWidth = 4;
  localparam int CountWidth = 6;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_BAD_TYPE = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLASS_DATA    = 2'd0,
    CLASS_CONTROL = 2'd1,
    CLASS_BAD     = 2'd2
  } seg_class_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [SegTypeWidth-1:0] seg_type;
    logic [HandleWidth-1:0]  pkt_handle;
  } in_t;

  typedef struct packed {
    status_t                status;
    logic [HandleWidth-1:0] out_handle;
    logic                   out_from_control;
    logic [CountWidth-1:0]  total_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  function automatic seg_class_t classify(input logic [SegTypeWidth-1:0] t);
    seg_class_t c;
    unique case (t)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd7: c = CLASS_DATA;
      4'd8, 4'd9, 4'd12, 4'd13, 4'd14, 4'd15: c = CLASS_CONTROL;
      default: c = CLASS_BAD;
    endcase
    return c;
  endfunction

endpackage

/* rtl/scpq_cell.sv */
// One queue cell: holds a single handle, loaded from the input or shifted from its neighbor.
module scpq_cell #(
  parameter int Width = scpq_pkg::DefHandleBits
) (
  input  logic               clk,
  input  scpq_pkg::cell_ctl_t ctl,
  input  logic [Width-1:0]   new_data,
  input  logic [Width-1:0]   shift_data,
  output logic [Width-1:0]   q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= new_data;
    end else if (ctl.shift) begin
      q <= shift_data;
    end
  end

endmodule

/* rtl/scpq_chain.sv */
// One bounded FIFO built as a row of cells that shift toward the head on every pop.
module scpq_chain #(
  parameter int Depth = scpq_pkg::DefQueueDepth,
  parameter int Width = scpq_pkg::DefHandleBits,
  localparam int FillWidth = $clog2(Depth + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 pop,
  input  logic [Width-1:0]     push_data,
  output logic [Width-1:0]     head_data,
  output logic [FillWidth-1:0] fill,
  output logic                 full
);

  logic [Width-1:0] cell_q [Depth];
  logic [FillWidth-1:0] fill_next;

  assign full = (fill == FillWidth'(Depth));
  assign head_data = cell_q[0];

  always_comb begin
    fill_next = fill;
    if (push) begin
      fill_next = fill + FillWidth'(1);
    end else if (pop) begin
      fill_next = fill - FillWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    scpq_pkg::cell_ctl_t ctl;
    logic [Width-1:0] neighbor;

    assign ctl.load = push && (fill == FillWidth'(i));
    assign ctl.shift = pop;

    if (i == Depth - 1) begin : g_last
      assign neighbor = '0;
    end else begin : g_mid
      assign neighbor = cell_q[i+1];
    end

    scpq_cell #(
      .Width(Width)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_data  (push_data),
      .shift_data(neighbor),
      .q         (cell_q[i])
    );
  end

endmodule

/* rtl/segment_class_priority_queue.sv */
// Top level of the strict-priority two-queue scheduler for segment handles.
// Each item is an enqueue, a dequeue, a peek or a no-op and yields exactly one result item
// in the cycle after it is accepted. An item is accepted in every cycle in which the result
// register is free or being emptied, so the block sustains one item per cycle while the
// output is not stalled; the result is registered. Each queue is a row of QUEUE_DEPTH
// cells that shift toward the head on a dequeue, and an enqueue writes the cell just
// past the last held entry. Control types are served before data types.
module segment_class_priority_queue #(
  parameter int QUEUE_DEPTH = scpq_pkg::DefQueueDepth,
  parameter int HANDLE_BITS = scpq_pkg::DefHandleBits
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  scpq_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output scpq_pkg::out_t out_item
);

  localparam int FillWidth = $clog2(QUEUE_DEPTH + 1);
  localparam int StoreBits = (HANDLE_BITS < scpq_pkg::HandleWidth) ? HANDLE_BITS
                                                                     : scpq_pkg::HandleWidth;

  logic accept;
  logic c_push, c_pop, c_full;
  logic d_push, d_pop, d_full;
  logic [FillWidth-1:0] c_fill, d_fill;
  logic [StoreBits-1:0] c_head, d_head, store_data;
  logic [FillWidth:0] total_after;
  scpq_pkg::seg_class_t seg_class;
  scpq_pkg::out_t result;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;
  assign store_data = in_item.pkt_handle[StoreBits-1:0];
  assign seg_class = scpq_pkg::classify(in_item.seg_type);

  always_comb begin
    c_push = 1'b0;
    c_pop = 1'b0;
    d_push = 1'b0;
    d_pop = 1'b0;
    result.status = scpq_pkg::STAT_OK;
    result.out_handle = '0;
    result.out_from_control = 1'b0;
    unique case (in_item.cmd)
      scpq_pkg::CMD_ENQ: begin
        if (seg_class == scpq_pkg::CLASS_CONTROL) begin
          if (c_full) begin
            result.status = scpq_pkg::STAT_FULL;
          end else begin
            c_push = accept;
          end
        end else if (seg_class == scpq_pkg::CLASS_DATA) begin
          if (d_full) begin
            result.status = scpq_pkg::STAT_FULL;
          end else begin
            d_push = accept;
          end
        end else begin
          result.status = scpq_pkg::STAT_BAD_TYPE;
        end
      end
      scpq_pkg::CMD_DEQ, scpq_pkg::CMD_PEEK: begin
        if (c_fill != '0) begin
          result.out_handle = scpq_pkg::HandleWidth'(c_head);
          result.out_from_control = 1'b1;
          c_pop = accept && (in_item.cmd == scpq_pkg::CMD_DEQ);
        end else if (d_fill != '0) begin
          result.out_handle = scpq_pkg::HandleWidth'(d_head);
          d_pop = accept && (in_item.cmd == scpq_pkg::CMD_DEQ);
        end else begin
          result.status = scpq_pkg::STAT_EMPTY;
        end
      end
      default: begin
      end
    endcase
    total_after = (FillWidth + 1)'(c_fill) + (FillWidth + 1)'(d_fill)
                + (FillWidth + 1)'(c_push || d_push) - (FillWidth + 1)'(c_pop || d_pop);
    result.total_count = scpq_pkg::CountWidth'(total_after);
  end

  scpq_chain #(
    .Depth(QUEUE_DEPTH),
    .Width(StoreBits)
  ) u_control (
    .clk      (clk),
    .rst      (rst),
    .push     (c_push),
    .pop      (c_pop),
    .push_data(store_data),
    .head_data(c_head),
    .fill     (c_fill),
    .full     (c_full)
  );

  scpq_chain #(
    .Depth(QUEUE_DEPTH),
    .Width(StoreBits)
  ) u_data (
    .clk      (clk),
    .rst      (rst),
    .push     (d_push),
    .pop      (d_pop),
    .push_data(store_data),
    .head_data(d_head),
    .fill     (d_fill),
    .full     (d_full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

endmodule
